### rtl/core/nsd_pkg.sv
// nsd_pkg: shared types and constants for the nesting depth sweep core
// holds the input and result word layouts; no dependencies
package nsd_pkg;

  // fixed field widths
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 16;

  // saturation value of a coverage count or a depth
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // increments applied over a range of the coverage tree
  localparam logic [CNT_W-1:0] DELTA_OPEN  = CNT_W'(1);
  localparam logic [CNT_W-1:0] DELTA_CLOSE = '1;

  // one vertical edge
  typedef struct packed {
    logic [IDX_W-1:0] y_start;
    logic [IDX_W-1:0] y_end;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [CNT_W-1:0] edge_depth;
    logic [CNT_W-1:0] max_depth;
  } out_word_t;

endpackage

### rtl/core/nsd_mem.sv
// nsd_mem: coverage tree storage, one write port and one registered read port
// depends on nsd_pkg for the count width
module nsd_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [nsd_pkg::CNT_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [nsd_pkg::CNT_W-1:0] rdata
);
  import nsd_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/nsd_seq.sv
// nsd_seq: sequencer with one shared 16-bit adder for the root-ward query walk,
// the depth step and the read-modify-write range update; depends on nsd_pkg
module nsd_seq #(
  parameter int unsigned COORDS = 1024,
  parameter int unsigned AW     = 11,
  parameter int unsigned NW     = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  nsd_pkg::in_word_t       in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output nsd_pkg::out_word_t      out_data,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [nsd_pkg::CNT_W-1:0] mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr,
  input  logic [nsd_pkg::CNT_W-1:0] mem_rdata
);
  import nsd_pkg::*;

  localparam int unsigned CW = (COORDS > 1) ? $clog2(COORDS) : 1;
  localparam logic [AW-1:0] LAST_NODE = AW'(2 * COORDS - 1);
  localparam logic [CW-1:0] TOP_IDX   = CW'(COORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_QUERY, S_DEPTH, S_LEVEL, S_WR_L, S_WR_R, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW-1:0]    node_r, node_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] best_r, best_nxt;
  logic             open_r, open_nxt;
  logic [NW-1:0]    l_r, l_nxt;
  logic [NW-1:0]    r_r, r_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  // shared adder
  logic [CNT_W-1:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  // input decode: clamp, edge direction, tree bounds
  logic             opening;
  logic [CW-1:0]    a_c, b_c, lo_c, hi_c;
  logic [AW-1:0]    leaf;
  logic [NW-1:0]    l_init, r_init;

  always_comb begin
    opening = in_data.y_start > in_data.y_end;
    if (32'(in_data.y_start) > 32'(COORDS - 1)) begin
      a_c = TOP_IDX;
    end else begin
      a_c = CW'(in_data.y_start);
    end
    if (32'(in_data.y_end) > 32'(COORDS - 1)) begin
      b_c = TOP_IDX;
    end else begin
      b_c = CW'(in_data.y_end);
    end
    lo_c   = opening ? b_c : a_c;
    hi_c   = opening ? a_c : b_c;
    leaf   = AW'(a_c) + AW'(COORDS);
    l_init = NW'(lo_c) + NW'(COORDS);
    r_init = NW'(hi_c) + NW'(COORDS) + NW'(1);
  end

  // helpers for the range walk
  logic [CNT_W-1:0] delta;
  logic [CNT_W-1:0] sat_depth;
  logic [NW-1:0]    l_inc, r_dec;
  assign delta     = open_r ? DELTA_OPEN : DELTA_CLOSE;
  assign sat_depth = (sum_r == CNT_MAX) ? CNT_MAX : add_y;
  assign l_inc     = l_r + NW'(1);
  assign r_dec     = r_r - NW'(1);

  // next-state and datapath control
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    pend_nxt      = pend_r;
    sum_nxt       = sum_r;
    depth_nxt     = depth_r;
    best_nxt      = best_r;
    open_nxt      = open_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = l_r[AW-1:0];
    mem_wdata     = add_y;
    mem_re        = 1'b0;
    mem_raddr     = node_r;
    add_a         = sum_r;
    add_b         = mem_rdata;

    // result word taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // zero the tree one node a cycle
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          open_nxt  = opening;
          node_nxt  = leaf;
          l_nxt     = l_init;
          r_nxt     = r_init;
          sum_nxt   = '0;
          pend_nxt  = 1'b0;
          depth_nxt = '0;
          state_nxt = opening ? S_QUERY : S_LEVEL;
        end
      end
      // leaf-to-root walk, read issued the cycle before its value enters the sum
      S_QUERY: begin
        if (pend_r) begin
          sum_nxt = add_y;
        end
        if (node_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = node_r;
          node_nxt  = node_r >> 1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DEPTH;
          end
        end
      end
      // depth is coverage plus one, saturating
      S_DEPTH: begin
        add_a     = sum_r;
        add_b     = CNT_W'(1);
        depth_nxt = sat_depth;
        if (sat_depth > best_r) begin
          best_nxt = sat_depth;
        end
        state_nxt = S_LEVEL;
      end
      // one tree level of the range update
      S_LEVEL: begin
        if (l_r >= r_r) begin
          state_nxt = S_FIN;
        end else if (l_r[0]) begin
          mem_re    = 1'b1;
          mem_raddr = l_r[AW-1:0];
          state_nxt = S_WR_L;
        end else if (r_r[0]) begin
          mem_re    = 1'b1;
          mem_raddr = r_dec[AW-1:0];
          r_nxt     = r_dec;
          state_nxt = S_WR_R;
        end else begin
          l_nxt = l_r >> 1;
          r_nxt = r_r >> 1;
        end
      end
      // write back left node, maybe read right node in the same cycle
      S_WR_L: begin
        add_a     = mem_rdata;
        add_b     = delta;
        mem_we    = 1'b1;
        mem_waddr = l_r[AW-1:0];
        if (r_r[0]) begin
          mem_re    = 1'b1;
          mem_raddr = r_dec[AW-1:0];
          r_nxt     = r_dec;
          l_nxt     = l_inc;
          state_nxt = S_WR_R;
        end else begin
          l_nxt     = l_inc >> 1;
          r_nxt     = r_r >> 1;
          state_nxt = S_LEVEL;
        end
      end
      // write back right node and climb a level
      S_WR_R: begin
        add_a     = mem_rdata;
        add_b     = delta;
        mem_we    = 1'b1;
        mem_waddr = r_r[AW-1:0];
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
        state_nxt = S_LEVEL;
      end
      // hand the result word to the output register
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.edge_depth = depth_r;
          out_data_nxt.max_depth  = best_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
    node_r     <= node_nxt;
    pend_r     <= pend_nxt;
    sum_r      <= sum_nxt;
    depth_r    <= depth_nxt;
    open_r     <= open_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/nesting_depth_sweep_segment_tree.sv
// nesting depth sweep core: range-add / point-query segment tree over COORDS rows
// an opening edge first walks the query path from its leaf to the root, then takes a depth step;
//   every edge then runs the range update level by level, reading and writing back the
//   boundary nodes of each level, and hands the result word to the output register
// throughput: one word at a time; the next word is taken the cycle after the result is loaded
// synchronous active-low reset, then a clearing pass over every tree node with in_stall high
module nesting_depth_sweep_segment_tree #(
  parameter int unsigned COORDS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nsd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output nsd_pkg::out_word_t out_data
);
  import nsd_pkg::*;

  localparam int unsigned DEPTH = 2 * COORDS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [CNT_W-1:0] mem_rdata;

  // sequencer with shared adder
  nsd_seq #(
    .COORDS (COORDS),
    .AW     (AW),
    .NW     (NW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // coverage tree
  nsd_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### rtl/core/nsd_chk.sv
// nsd_chk: port-level checks on the nesting depth sweep core
// depends on nsd_pkg; bound to the top level below
module nsd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input nsd_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input nsd_pkg::out_word_t out_data
);
  import nsd_pkg::*;

  // a stalled result word stays offered and keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  // a stalled input word stays offered and keeps its value
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word dropped or changed while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // depth of an edge never exceeds the running maximum
  a_depth_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.edge_depth <= out_data.max_depth)
    else $error("edge depth above running maximum");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind nesting_depth_sweep_segment_tree nsd_chk u_nsd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
